// ===== sv/jls_pkg.sv =====
// Package for the Jacobi linear solver: sizes, field widths and state codes.
// No dependencies.
`default_nettype none
package jls_pkg;
    localparam int SizeDefault     = 4;
    localparam int FracBitsDefault = 24;
    localparam int ValW            = 48;
    localparam int IterW           = 20;
    localparam int TolW            = 32;
    localparam int RowW            = 2;
    localparam int ColW            = 3;
    localparam int IdxW            = 2;
    localparam int StatW           = 2;
    localparam int CfgIdxW         = 1;
    localparam int CfgDataW        = 32;

    localparam logic [IterW-1:0] MaxIterReset = 20'd200000;
    localparam logic [TolW-1:0]  TolReset     = 32'd4;

    localparam logic [CfgIdxW-1:0] RegMaxIter = 1'b0;
    localparam logic [CfgIdxW-1:0] RegTol     = 1'b1;

    localparam logic [StatW-1:0] StConverged = 2'd0;
    localparam logic [StatW-1:0] StLimit     = 2'd1;
    localparam logic [StatW-1:0] StZeroDiag  = 2'd2;

    localparam logic [ValW-1:0] PosMax = {1'b0, {(ValW-1){1'b1}}};
    localparam logic [ValW-1:0] NegMin = {1'b1, {(ValW-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE, S_DIAG, S_INIT, S_INIT_W, S_ROW, S_MUL, S_MUL_W, S_DIV, S_DIV_W,
        S_TOL, S_TOL_W, S_DECIDE, S_OUT
    } state_t;

    // Saturate a sign and magnitude to the signed 48-bit range.
    function automatic logic [ValW-1:0] sat_mag(input logic neg, input logic [127:0] m);
        logic [ValW-1:0] r;
        begin
            if (neg)
                r = (m >= {80'd0, NegMin}) ? NegMin : (~m[ValW-1:0] + 1'b1);
            else
                r = (m > {80'd0, PosMax}) ? PosMax : m[ValW-1:0];
            return r;
        end
    endfunction
endpackage
`default_nettype wire

// ===== sv/jls_if.sv =====
// Valid/ready channel interfaces for the solver: load, result and config.
// Depends on jls_pkg.
`default_nettype none
interface jls_load_if import jls_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [RowW-1:0]   row;
    logic [ColW-1:0]   column;
    logic [ValW-1:0]   value;
    logic              last_load;
    modport source (output valid, row, column, value, last_load, input ready);
    modport sink   (input valid, row, column, value, last_load, output ready);
endinterface

interface jls_result_if import jls_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [IdxW-1:0]   index;
    logic [ValW-1:0]   solution;
    logic [IterW-1:0]  iterations;
    logic [StatW-1:0]  status;
    logic              last_of_run;
    modport source (output valid, index, solution, iterations, status, last_of_run,
                    input ready);
    modport sink   (input valid, index, solution, iterations, status, last_of_run,
                    output ready);
endinterface

interface jls_cfg_if import jls_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/jls_mul.sv =====
// Shared multi-cycle shift-add multiplier, unsigned 64x64 -> 128, 8 bits a cycle.
// Depends on jls_pkg.
`default_nettype none
module jls_mul import jls_pkg::*; (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [63:0]  a,
    input  wire logic [63:0]  b,
    output logic              done,
    output logic [127:0]      prod
);
    logic [127:0] acc_reg, acc_next;
    logic [63:0]  b_reg, b_next;
    logic [127:0] a_reg, a_next;
    logic [3:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic [127:0] part;

    always_comb
    begin
        part = '0;
        for (int k = 0; k < 8; k++)
            if (b_reg[k]) part = part + (a_reg << k);
    end

    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            acc_next  = '0;
            a_next    = {64'd0, a};
            b_next    = b;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + part;
            a_next   = a_reg << 8;
            b_next   = b_reg >> 8;
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd7) busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign done = busy_reg && cnt_reg == 4'd8 ? 1'b0 : (!busy_reg && cnt_reg == 4'd8);
    assign prod = acc_reg;
endmodule
`default_nettype wire

// ===== sv/jls_div.sv =====
// Shared restoring divider: 128-bit dividend by 64-bit divisor, one bit a cycle,
// quotient saturates once it passes 48 bits. Depends on jls_pkg.
`default_nettype none
module jls_div import jls_pkg::*; (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [127:0] num,
    input  wire logic [63:0]  den,
    output logic              done,
    output logic [63:0]       quo,
    output logic              sat
);
    logic [127:0] n_reg, n_next;
    logic [63:0]  d_reg, d_next, r_reg, r_next, q_reg, q_next;
    logic         sat_reg, sat_next, busy_reg, busy_next, done_reg, done_next;
    logic [7:0]   cnt_reg, cnt_next;
    logic [64:0]  rs;
    logic [63:0]  qs;
    logic         satn;

    always_comb
    begin
        n_next = n_reg; d_next = d_reg; r_next = r_reg; q_next = q_reg;
        sat_next = sat_reg; busy_next = busy_reg; cnt_next = cnt_reg;
        done_next = 1'b0;
        rs = {r_reg, n_reg[127]};
        satn = sat_reg || (q_reg > {16'd0, {ValW{1'b1}}});
        qs = satn ? q_reg : (q_reg << 1);
        if (start)
        begin
            n_next = num; d_next = den; r_next = '0; q_next = '0;
            sat_next = 1'b0; busy_next = 1'b1; cnt_next = '0;
        end
        else if (busy_reg)
        begin
            if (rs >= {1'b0, d_reg})
            begin
                rs = rs - {1'b0, d_reg};
                qs[0] = 1'b1;
            end
            r_next   = rs[63:0];
            q_next   = qs;
            sat_next = satn;
            n_next   = n_reg << 1;
            cnt_next = cnt_reg + 8'd1;
            if (cnt_reg == 8'd127)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next; d_reg <= d_next; r_reg <= r_next;
        q_reg <= q_next; sat_reg <= sat_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;
    assign sat  = sat_reg;
endmodule
`default_nettype wire

// ===== sv/jacobi_linear_solver_unit.sv =====
// Top level of the Jacobi solver: load store, sequencer, shared multiplier/divider.
// Depends on jls_pkg, jls_if, jls_mul and jls_div.
`default_nettype none
// Load is ready only while the solver is idle. A request with last_load starts a solve,
// and load is not ready until the last result has gone out. The solve first checks the
// SIZE diagonal entries, one a cycle; a zero diagonal sends it straight to the results.
// Otherwise it forms the starting guess with one divide per row. Each iteration then
// takes, per row, SIZE-1 products on the shared multiplier, one row divide and one
// tolerance check on the multiplier. The SIZE results then go out in order, held by any
// result stalls. The one 128-bit restoring divider, one quotient bit a cycle, takes
// most of the solve time.
module jacobi_linear_solver_unit import jls_pkg::*; #(
    parameter int SIZE      = SizeDefault,
    parameter int FRAC_BITS = FracBitsDefault
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    jls_load_if.sink    load,
    jls_result_if.source result,
    jls_cfg_if.sink     cfg
);
    localparam int SW = $clog2(SIZE);

    logic [ValW-1:0]  a_reg [SIZE][SIZE];
    logic [ValW-1:0]  b_reg [SIZE];
    logic [ValW-1:0]  xp_reg [SIZE];
    logic [ValW-1:0]  xn_reg [SIZE];
    logic [IterW-1:0] maxit_reg, it_reg, it_next;
    logic [TolW-1:0]  tol_reg;
    state_t           st_reg, st_next;
    logic [SW-1:0]    i_reg, i_next, j_reg, j_next;
    logic [ValW+SW+1:0] acc_reg, acc_next;
    logic             conv_reg, conv_next, zd_reg, zd_next;
    logic [StatW-1:0] stat_reg, stat_next;

    logic             m_start, d_start, m_done, d_done, d_sat;
    logic [63:0]      m_a, m_b, d_den, d_quo;
    logic [127:0]     m_prod, d_num;
    logic             mul_res_neg, div_neg;
    logic [ValW-1:0]  prod_val, quo_val;
    logic [63:0]      nmag, amag;

    function automatic logic [63:0] mag48(input logic [ValW-1:0] v);
        return v[ValW-1] ? (64'd0 - {{(64-ValW){1'b1}}, v}) : {{(64-ValW){1'b0}}, v};
    endfunction

    wire load_acc = load.valid && load.ready;

    // config
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            maxit_reg <= MaxIterReset;
            tol_reg   <= TolReset;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                RegMaxIter: maxit_reg <= cfg.data[IterW-1:0];
                RegTol:     tol_reg   <= cfg.data[TolW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_acc && {1'b0, load.row} < (RowW+1)'(SIZE))
        begin
            if ({1'b0, load.column} < (ColW+1)'(SIZE))
                a_reg[load.row[SW-1:0]][load.column[SW-1:0]] <= load.value;
            else if ({1'b0, load.column} == (ColW+1)'(SIZE))
                b_reg[load.row[SW-1:0]] <= load.value;
        end
    end

    // Multiplier operands: a[i][j] * xp[j]; divider: acc or b over a[i][i].
    wire [ValW-1:0] aij = a_reg[i_reg][j_reg];
    wire [ValW-1:0] aii = a_reg[i_reg][i_reg];
    assign m_a = mag48(aij);
    assign m_b = mag48(xp_reg[j_reg]);
    assign mul_res_neg = aij[ValW-1] ^ xp_reg[j_reg][ValW-1];
    wire [127:0] pshift = m_prod >> FRAC_BITS;
    assign prod_val = sat_mag(mul_res_neg, pshift);

    // numerator: exact acc (or b in init), signed
    wire [ValW+SW+1:0] numer = (st_reg == S_INIT || st_reg == S_INIT_W)
                             ? {{(SW+2){b_reg[i_reg][ValW-1]}}, b_reg[i_reg]} : acc_reg;
    wire [ValW+SW+1:0] nabs = numer[ValW+SW+1] ? (~numer + 1'b1) : numer;
    assign d_num  = {{(128-(ValW+SW+2)){1'b0}}, nabs} << FRAC_BITS;
    assign d_den  = mag48(aii);
    assign div_neg = numer[ValW+SW+1] ^ aii[ValW-1];
    assign quo_val = sat_mag(div_neg, d_sat ? {128{1'b1}} : {64'd0, d_quo});

    // tolerance compare: |new-old|*2^32 <= tol*|new| (mul reused)
    wire [ValW:0] diff = {xn_reg[i_reg][ValW-1], xn_reg[i_reg]}
                       - {xp_reg[i_reg][ValW-1], xp_reg[i_reg]};
    wire [ValW:0] dabs = diff[ValW] ? (~diff + 1'b1) : diff;
    assign nmag = mag48(xn_reg[i_reg]);
    assign amag = {32'd0, tol_reg};

    logic [63:0] mop_a, mop_b;
    always_comb
    begin
        mop_a = m_a;
        mop_b = m_b;
        if (st_reg == S_TOL || st_reg == S_TOL_W)
        begin
            mop_a = amag;
            mop_b = nmag;
        end
    end

    jls_mul u_mul (.clk, .rst_n, .start(m_start), .a(mop_a), .b(mop_b),
                   .done(m_done), .prod(m_prod));
    jls_div u_div (.clk, .rst_n, .start(d_start), .num(d_num), .den(d_den),
                   .done(d_done), .quo(d_quo), .sat(d_sat));

    wire        last_i = i_reg == SW'(SIZE-1);

    // next state
    always_comb
    begin
        st_next = st_reg; i_next = i_reg; j_next = j_reg; acc_next = acc_reg;
        conv_next = conv_reg; zd_next = zd_reg; it_next = it_reg; stat_next = stat_reg;
        unique case (st_reg)
            S_IDLE:
                if (load_acc && load.last_load)
                begin
                    st_next = S_DIAG; i_next = '0; zd_next = 1'b0;
                end
            S_DIAG:
            begin
                if (aii == '0) zd_next = 1'b1;
                i_next = i_reg + 1'b1;
                if (last_i)
                begin
                    i_next = '0;
                    if (zd_reg || aii == '0)
                    begin
                        st_next = S_OUT; stat_next = StZeroDiag; it_next = '0;
                    end
                    else st_next = S_INIT;
                end
            end
            S_INIT: st_next = S_INIT_W;
            S_INIT_W:
                if (d_done)
                begin
                    i_next = i_reg + 1'b1;
                    if (last_i)
                    begin
                        i_next = '0; it_next = IterW'(1); st_next = S_ROW; conv_next = 1'b1;
                    end
                    else st_next = S_INIT;
                end
            S_ROW:
            begin
                acc_next = {{(SW+2){b_reg[i_reg][ValW-1]}}, b_reg[i_reg]};
                j_next = '0;
                st_next = (i_reg == '0) ? ((SIZE > 1) ? S_MUL : S_DIV) : S_MUL;
                if (i_reg == '0) j_next = SW'(1);
            end
            S_MUL: st_next = S_MUL_W;
            S_MUL_W:
                if (m_done)
                begin
                    acc_next = acc_reg - {{(SW+2){prod_val[ValW-1]}}, prod_val};
                    if (j_reg == SW'(SIZE-1) ||
                        (j_reg == SW'(SIZE-2) && i_reg == SW'(SIZE-1)))
                        st_next = S_DIV;
                    else
                    begin
                        j_next = j_reg + 1'b1;
                        if (j_next == i_reg) j_next = j_reg + 2'd2;
                        st_next = S_MUL;
                    end
                end
            S_DIV: st_next = S_DIV_W;
            S_DIV_W: if (d_done) st_next = S_TOL;
            S_TOL: st_next = S_TOL_W;
            S_TOL_W:
                if (m_done)
                begin
                    if ({47'd0, dabs, 32'd0} > m_prod) conv_next = 1'b0;
                    i_next = i_reg + 1'b1;
                    st_next = last_i ? S_DECIDE : S_ROW;
                end
            S_DECIDE:
            begin
                i_next = '0;
                if (conv_reg)
                begin
                    st_next = S_OUT; stat_next = StConverged;
                end
                else if (it_reg >= maxit_reg)
                begin
                    st_next = S_OUT; stat_next = StLimit;
                end
                else
                begin
                    it_next = it_reg + 1'b1; conv_next = 1'b1; st_next = S_ROW;
                end
            end
            S_OUT:
                if (result.ready)
                begin
                    i_next = i_reg + 1'b1;
                    if (last_i) st_next = S_IDLE;
                end
            default: st_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        m_start = 1'b0;
        d_start = 1'b0;
        unique case (st_reg) inside
            S_MUL, S_TOL:  m_start = 1'b1;
            S_INIT, S_DIV: d_start = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE; i_reg <= '0; j_reg <= '0; it_reg <= '0;
            conv_reg <= 1'b0; zd_reg <= 1'b0; stat_reg <= StConverged;
        end
        else
        begin
            st_reg <= st_next; i_reg <= i_next; j_reg <= j_next; it_reg <= it_next;
            conv_reg <= conv_next; zd_reg <= zd_next; stat_reg <= stat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (st_reg == S_INIT_W && d_done) xp_reg[i_reg] <= quo_val;
        if (st_reg == S_DIV_W && d_done)  xn_reg[i_reg] <= quo_val;
        if (st_reg == S_DECIDE && !conv_reg && it_reg < maxit_reg)
            for (int k = 0; k < SIZE; k++) xp_reg[k] <= xn_reg[k];
    end

    assign load.ready         = st_reg == S_IDLE;
    assign result.valid       = st_reg == S_OUT;
    assign result.index       = IdxW'(i_reg);
    assign result.solution    = (stat_reg == StZeroDiag) ? '0 : xn_reg[i_reg];
    assign result.iterations  = it_reg;
    assign result.status      = stat_reg;
    assign result.last_of_run = last_i;
endmodule
`default_nettype wire

// ===== dv/jacobi_linear_solver_unit_tb.sv =====
// Testbench for the Jacobi linear solver: it loads 4x4 systems and predicts each solve in
// 128-bit fixed point. Depends on jls_pkg, jls_if and jacobi_linear_solver_unit.
`timescale 1ns / 100ps
module jacobi_linear_solver_unit_tb;
    import jls_pkg::*;

    localparam int N = SizeDefault;
    localparam int FB = FracBitsDefault;
    localparam logic [ColW-1:0] RhsCol = ColW'(N);
    localparam longint VMax = 64'sh7FFFFFFFFFFF;
    localparam longint VMin = -64'sh800000000000;
    localparam int TotalLoads = 450;

    typedef struct {
        logic [IdxW-1:0]  index;
        logic [ValW-1:0]  solution;
        logic [IterW-1:0] iterations;
        logic [StatW-1:0] status;
        logic             last_of_run;
    } answer_t;

    class solve_tracker;
        longint           coef[N*N];
        longint           rhs[N];
        longint           prev_x[N];
        longint           next_x[N];
        logic [IterW-1:0] iter_limit = MaxIterReset;
        logic [TolW-1:0]  tol = TolReset;
        answer_t          awaited[$];
        int               errors = 0;

        function logic [127:0] magnitude(longint v);
            return (v < 0) ? 128'(-v) : 128'(v);
        endfunction

        function longint clamp(bit neg, logic [127:0] m);
            if (neg)
                return (m > 128'(64'h800000000000)) ? VMin : -longint'(m[63:0]);
            return (m > 128'(VMax)) ? VMax : longint'(m[63:0]);
        endfunction

        function longint mul_q(longint a, longint x);
            return clamp((a < 0) != (x < 0), (magnitude(a) * magnitude(x)) >> FB);
        endfunction

        function longint div_q(longint num, longint den);
            return clamp((num < 0) != (den < 0), (magnitude(num) << FB) / magnitude(den));
        endfunction

        function bit settled(longint nw, longint old);
            return (magnitude(nw - old) << 32) <= 128'(tol) * magnitude(nw);
        endfunction

        function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
            if (idx == RegMaxIter) iter_limit = data[IterW-1:0];
            else tol = data;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Store one request; a final load runs the whole solve.
        function void note_load(logic [RowW-1:0] r, logic [ColW-1:0] c,
                                logic [ValW-1:0] v, bit fin);
            longint val;
            longint acc;
            bit zero_diag;
            bit conv;
            logic [StatW-1:0] st;
            logic [IterW-1:0] count;
            answer_t a;
            val = {{16{v[ValW-1]}}, v};
            if (c < N) coef[r*N + c] = val;
            else if (c == RhsCol) rhs[r] = val;
            if (!fin) return;
            zero_diag = 0;
            for (int i = 0; i < N; i++)
                if (coef[i*N + i] == 0) zero_diag = 1;
            if (zero_diag) begin
                st = StZeroDiag;
                count = 0;
            end
            else begin
                for (int i = 0; i < N; i++) prev_x[i] = div_q(rhs[i], coef[i*N + i]);
                count = 1;
                forever begin
                    conv = 1;
                    for (int i = 0; i < N; i++) begin
                        acc = rhs[i];
                        for (int j = 0; j < N; j++)
                            if (j != i) acc -= mul_q(coef[i*N + j], prev_x[j]);
                        next_x[i] = div_q(acc, coef[i*N + i]);
                        if (!settled(next_x[i], prev_x[i])) conv = 0;
                    end
                    if (conv) begin
                        st = StConverged;
                        break;
                    end
                    if (count >= iter_limit) begin
                        st = StLimit;
                        break;
                    end
                    prev_x = next_x;
                    count++;
                end
            end
            for (int i = 0; i < N; i++) begin
                a.index = IdxW'(i);
                a.solution = zero_diag ? '0 : next_x[i][ValW-1:0];
                a.iterations = count;
                a.status = st;
                a.last_of_run = (i == N - 1);
                awaited.push_back(a);
            end
        endfunction

        function void check(answer_t got);
            answer_t want;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result idx=%0d sol=%h", $realtime, got.index,
                         got.solution);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.index !== want.index || got.solution !== want.solution ||
                got.iterations !== want.iterations || got.status !== want.status ||
                got.last_of_run !== want.last_of_run) begin
                $display("%0t: mismatch expected idx=%0d sol=%h it=%0d st=%0d last=%0d",
                         $realtime, want.index, want.solution, want.iterations, want.status,
                         want.last_of_run);
                $display("%0t:          actual   idx=%0d sol=%h it=%0d st=%0d last=%0d",
                         $realtime, got.index, got.solution, got.iterations, got.status,
                         got.last_of_run);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    jls_load_if   load_ch();
    jls_result_if res_ch();
    jls_cfg_if    cfg_ch();

    solve_tracker tracker = new();
    int  loads_sent = 0;
    bit  quiet = 0;
    bit  hold_armed = 0;
    bit  hold_done = 0;

    jacobi_linear_solver_unit DUT (
        .clk(clk), .rst_n(rst_n), .load(load_ch), .result(res_ch), .cfg(cfg_ch)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #100ms;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        answer_t got;
        if (res_ch.valid && res_ch.ready) begin
            got.index = res_ch.index;
            got.solution = res_ch.solution;
            got.iterations = res_ch.iterations;
            got.status = res_ch.status;
            got.last_of_run = res_ch.last_of_run;
            tracker.check(got);
        end
    end

    // Result side: random stalls, plus one long hold-off once the random phase starts.
    initial
    begin
        res_ch.ready <= 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_armed && !hold_done && res_ch.valid) begin
                res_ch.ready <= 0;
                repeat (2000) @(posedge clk);
                hold_done = 1;
            end
            else if (!quiet && $urandom_range(0, 4) == 0) begin
                res_ch.ready <= 0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            else
                res_ch.ready <= 1;
        end
    end

    task automatic send_load(logic [RowW-1:0] r, logic [ColW-1:0] c, logic [ValW-1:0] v,
                             bit fin);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            load_ch.valid <= 0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        load_ch.valid <= 1;
        load_ch.row <= r;
        load_ch.column <= c;
        load_ch.value <= v;
        load_ch.last_load <= fin;
        do @(posedge clk); while (!load_ch.ready);
        tracker.note_load(r, c, v, fin);
        loads_sent++;
        quiet = (loads_sent >= TotalLoads - 45);
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
        cfg_ch.valid <= 1;
        cfg_ch.index <= idx;
        cfg_ch.data <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        tracker.set_reg(idx, data);
        cfg_ch.valid <= 0;
        @(posedge clk);
    endtask

    // Drop load valid, drain all results, then wait with the bus idle.
    task automatic drain();
        load_ch.valid <= 0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    function automatic logic [ValW-1:0] signed_rand(int unsigned lim);
        longint m;
        m = $urandom_range(0, lim);
        return ValW'($urandom_range(0, 1) ? -m : m);
    endfunction

    function automatic logic [ValW-1:0] full_rand();
        return ValW'({$urandom(), $urandom()} >> 16);
    endfunction

    // Row-major system, wide diagonal, one zero if kill_diag; noise requests mixed in.
    task automatic send_system(bit kill_diag);
        logic [ValW-1:0] v;
        int zr;
        zr = $urandom_range(0, N - 1);
        for (int r = 0; r < N; r++)
            for (int c = 0; c <= N; c++) begin
                if ($urandom_range(0, 99) < 15)
                    send_load(RowW'($urandom()), ColW'($urandom()), full_rand(),
                              $urandom_range(0, 99) < 3);
                if (c == N) v = signed_rand(32'h3FFFFFFF);
                else if (c != r) v = signed_rand(32'h000FFFFF);
                else if (kill_diag && r == zr) v = '0;
                else v = signed_rand(32'h0F000000) + 48'h1000000;
                if (c == r && v == 0 && !(kill_diag && r == zr)) v = 48'h1000000;
                send_load(RowW'(r), ColW'(c), v, (r == N - 1) && (c == N));
            end
    endtask

    initial
    begin
        logic [IterW-1:0] lim;
        logic [TolW-1:0] t;
        rst_n <= 0;
        load_ch.valid <= 0;
        load_ch.row <= '0;
        load_ch.column <= '0;
        load_ch.value <= '0;
        load_ch.last_load <= 0;
        cfg_ch.valid <= 0;
        cfg_ch.index <= RegMaxIter;
        cfg_ch.data <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Diagonal system with extreme entries: converges on the first pass.
        write_reg(RegMaxIter, 32'hFFFFF);
        write_reg(RegTol, 32'h0);
        for (int r = 0; r < N; r++)
            for (int c = 0; c < N; c++)
                if (r != c) send_load(RowW'(r), ColW'(c), '0, 0);
        send_load(0, 0, PosMax, 0);
        send_load(1, 1, NegMin, 0);
        send_load(2, 2, 48'h1, 0);
        send_load(3, 3, -48'sh1000000, 0);
        send_load(0, RhsCol, NegMin, 0);
        send_load(1, RhsCol, PosMax, 0);
        send_load(2, RhsCol, 48'h1, 0);
        send_load(3, RhsCol, '0, 1);
        // Zero diagonal, then out-of-range columns with a final load.
        send_load(2, 2, '0, 1);
        send_load(1, 3'd5, PosMax, 0);
        send_load(3, 3'd6, NegMin, 0);
        send_load(0, 3'd7, 48'h123456789ABC, 1);
        send_load(2, 2, 48'h7FFF00000000, 1);
        drain();

        write_reg(RegMaxIter, 32'h0);
        write_reg(RegTol, 32'hFFFFFFFF);
        send_system(0);
        drain();
        write_reg(RegMaxIter, 32'h1);
        write_reg(RegTol, TolReset);
        send_system(0);
        drain();

        hold_armed = 1;
        while (loads_sent < TotalLoads) begin
            case ($urandom_range(0, 3))
                0: lim = IterW'($urandom_range(0, 1));
                default: lim = IterW'($urandom_range(2, 20));
            endcase
            case ($urandom_range(0, 3))
                0: t = '0;
                1: t = '1;
                2: t = TolReset;
                default: t = $urandom();
            endcase
            write_reg(RegMaxIter, {12'($urandom_range(0, 4095)), lim});
            write_reg(RegTol, t);
            repeat ($urandom_range(1, 3)) send_system($urandom_range(0, 9) == 0);
            drain();
        end

        if (tracker.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== sim.f =====
sv/jls_pkg.sv
sv/jls_if.sv
sv/jls_mul.sv
sv/jls_div.sv
sv/jacobi_linear_solver_unit.sv
dv/jacobi_linear_solver_unit_tb.sv
